// ===== rtl/fse_pkg.sv =====
// Shared widths, defaults and controller/datapath command and status types.
package fse_pkg;

  localparam int MAX_ELEMENTS_DEF = 32;
  localparam int ELEM_W           = 16;
  localparam int WORD_W           = 32;

  // Input item kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RANDOM = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_load;  // store the offered element, bump the count
    logic start_shuf;   // set swap index to the new count minus one
    logic mod_start;    // launch word mod (i+1)
    logic cap_i;        // hold entry i read in the previous cycle
    logic rd_j;         // address the memory read port with j
    logic wr_i;         // entry i takes entry j
    logic wr_j;         // entry j takes the held entry i, step i down
    logic rd_emit;      // address the memory read port with the emit index
    logic emit_load;    // move the read data into the output register
    logic clear;        // empty the array as the final item enters the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_single;  // count after this load is at most one
    logic mod_busy;
    logic mod_done;
    logic i_is_one;
    logic i_nonzero;
    logic out_free;     // output register can take an item this cycle
    logic emit_last;    // emit index points at the final element
  } status_t;

endpackage

// ===== rtl/fse_in_if.sv =====
// Input channel: element loads and random words.
interface fse_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [fse_pkg::ELEM_W-1:0]  element;
  logic                        last;
  logic [fse_pkg::WORD_W-1:0]  random_word;

  modport source (output valid, mode, element, last, random_word, input ready);
  modport sink   (input valid, mode, element, last, random_word, output ready);
endinterface

// ===== rtl/fse_out_if.sv =====
// Output channel: shuffled elements in index order.
interface fse_out_if;
  logic                        valid;
  logic                        ready;
  logic [fse_pkg::ELEM_W-1:0]  value;
  logic                        final_res;

  modport source (output valid, value, final_res, input ready);
  modport sink   (input valid, value, final_res, output ready);
endinterface

// ===== rtl/fse_mod.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor in one bit per cycle.
module fse_mod #(
  parameter int DW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fse_pkg::WORD_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DW-1:0]              rem
);

  localparam int CNT_W = $clog2(fse_pkg::WORD_W);

  logic [fse_pkg::WORD_W-1:0] shreg;
  logic [DW-1:0]              dvsr;
  logic [CNT_W-1:0]           cnt;
  logic [DW:0]                trial;
  logic [DW:0]                diff;

  assign trial = {rem, shreg[fse_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(fse_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[fse_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        rem <= diff[DW-1:0];
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

endmodule

// ===== rtl/fse_dp.sv =====
// Datapath: array memory, counters, swap registers, modulo unit, output register.
module fse_dp #(
  parameter int MAX_ELEMENTS = fse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fse_pkg::cmd_t              cmd,
  output fse_pkg::status_t           status,
  input  logic [fse_pkg::ELEM_W-1:0] element,
  input  logic [fse_pkg::WORD_W-1:0] random_word,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [fse_pkg::ELEM_W-1:0] out_value,
  output logic                       out_final
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [fse_pkg::ELEM_W-1:0] mem [MAX_ELEMENTS];
  logic [fse_pkg::ELEM_W-1:0] rd_data;
  logic [fse_pkg::ELEM_W-1:0] tmp;
  logic [IW-1:0]              rd_addr;
  logic [IW-1:0]              wr_addr;
  logic [fse_pkg::ELEM_W-1:0] wr_data;
  logic                       wr_en;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_m1;
  logic          not_full;
  logic [IW-1:0] swap_i;
  logic [IW-1:0] emit_k;
  logic [IW-1:0] swap_j;
  logic [CW-1:0] mod_rem;
  logic [CW-1:0] divisor;

  assign not_full   = (count != CW'(MAX_ELEMENTS));
  assign count_next = not_full ? count + CW'(1) : count;
  assign count_m1   = count - CW'(1);
  assign divisor    = CW'({1'b0, swap_i} + 1'b1);
  assign swap_j     = mod_rem[IW-1:0];

  fse_mod #(.DW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (random_word),
    .divisor  (divisor),
    .busy     (status.mod_busy),
    .done     (status.mod_done),
    .rem      (mod_rem)
  );

  // Memory port selection
  always_comb begin
    if (cmd.rd_j) begin
      rd_addr = swap_j;
    end else if (cmd.rd_emit) begin
      rd_addr = emit_k;
    end else begin
      rd_addr = swap_i;
    end
    wr_en   = 1'b0;
    wr_addr = swap_i;
    wr_data = rd_data;
    if (cmd.accept_load) begin
      wr_en   = not_full;
      wr_addr = count[IW-1:0];
      wr_data = element;
    end else if (cmd.wr_i) begin
      wr_en = 1'b1;
    end else if (cmd.wr_j) begin
      wr_en   = 1'b1;
      wr_addr = swap_j;
      wr_data = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      tmp <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      swap_i <= '0;
      emit_k <= '0;
    end else begin
      if (cmd.clear) begin
        count  <= '0;
        emit_k <= '0;
      end else if (cmd.emit_load) begin
        emit_k <= emit_k + IW'(1);
      end else if (cmd.accept_load) begin
        count <= count_next;
      end
      if (cmd.start_shuf) begin
        swap_i <= IW'(count_next - CW'(1));
      end else if (cmd.wr_j) begin
        swap_i <= swap_i - IW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value <= rd_data;
      out_final <= status.emit_last;
    end
  end

  assign status.load_single = (count_next <= CW'(1));
  assign status.i_is_one    = (swap_i == IW'(1));
  assign status.i_nonzero   = (swap_i != '0);
  assign status.out_free    = !out_valid || out_ready;
  assign status.emit_last   = (emit_k == count_m1[IW-1:0]);

endmodule

// ===== rtl/fse_ctrl.sv =====
// Controller: load, shuffle and emit sequencing.
module fse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_mode,
  input  logic             in_last,
  output logic             in_ready,
  input  fse_pkg::status_t status,
  output fse_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_SHUF    = 8'b0000_0010,
    S_MOD     = 8'b0000_0100,
    S_RD_J    = 8'b0000_1000,
    S_WR_I    = 8'b0001_0000,
    S_WR_J    = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT_LD = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && in_mode == fse_pkg::MODE_LOAD) begin
          cmd.accept_load = 1'b1;
          if (in_last) begin
            if (status.load_single) begin
              state_next = S_EMIT_RD;
            end else begin
              cmd.start_shuf = 1'b1;
              state_next     = S_SHUF;
            end
          end
        end
      end
      S_SHUF: begin
        in_ready = 1'b1;
        if (in_valid && in_mode == fse_pkg::MODE_RANDOM) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        // read port sits on entry i; data lands as the remainder settles
        if (status.mod_done) begin
          state_next = S_RD_J;
        end
      end
      S_RD_J: begin
        cmd.cap_i  = 1'b1;
        cmd.rd_j   = 1'b1;
        state_next = S_WR_I;
      end
      S_WR_I: begin
        cmd.wr_i   = 1'b1;
        state_next = S_WR_J;
      end
      S_WR_J: begin
        cmd.wr_j   = 1'b1;
        state_next = status.i_is_one ? S_EMIT_RD : S_SHUF;
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.rd_emit = 1'b1;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  a_reset_load: assert property (@(posedge clk) rst |=> state == S_LOAD)
    else $error("controller not in load state after reset");

  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    status.mod_done |-> state == S_MOD)
    else $error("remainder finished outside the modulo wait");

  a_busy_in_mod: assert property (@(posedge clk) disable iff (rst)
    status.mod_busy |-> state == S_MOD)
    else $error("modulo unit running outside the modulo wait");

  a_shuf_index: assert property (@(posedge clk) disable iff (rst)
    state == S_SHUF |-> status.i_nonzero)
    else $error("waiting for a random word with swap index zero");

endmodule

// ===== rtl/fisher_yates_shuffle_engine.sv =====
// Top level of the Fisher-Yates shuffle engine.
//
// Usage:
//   in_ch carries one item per handshake (valid && ready). With mode 0 the item
//   loads one 16-bit element; last marks the final one. Loads past MAX_ELEMENTS
//   are dropped, though a last mark on them still closes the array. With mode 1
//   the item supplies a 32-bit random word for one swap step. Items of the
//   wrong kind for the current phase are accepted and ignored.
//   out_ch delivers the shuffled array in index order, final_res on the last.
// Sequence:
//   A random word is accepted, then the bit-serial remainder word mod (i+1)
//   runs, one step per bit of the 32-bit word and then done; then the swap
//   goes through the one read port and one write port of the array memory.
//   An array of n > 1 elements needs n-1 words. Emitting reads each element
//   and moves it into the output register whenever that register is free.
//   A one-element array starts emitting right after its load.
//   in_ch.ready is low while a remainder, a swap or the emit runs.
// Reset (rst, synchronous): returns to loading with an empty array; the output
//   register is emptied. Memory contents are not cleared.
// Stall: a held out_ch item freezes the emit; the output register lets the
//   block take the next load once the final item sits in it.
module fisher_yates_shuffle_engine #(
  parameter int MAX_ELEMENTS = fse_pkg::MAX_ELEMENTS_DEF
) (
  input logic       clk,
  input logic       rst,
  fse_in_if.sink    in_ch,
  fse_out_if.source out_ch
);

  fse_pkg::cmd_t    cmd;
  fse_pkg::status_t status;

  // Sequence loading, swapping and emitting
  fse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the array, compute j and drive the output register
  fse_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .element     (in_ch.element),
    .random_word (in_ch.random_word),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_value   (out_ch.value),
    .out_final   (out_ch.final_res)
  );

endmodule
